>>> hdl/kcs_pkg.sv
// shared types, constants and codes for the keyframe curve sampler
package kcs_pkg;

  // default sizes of the key stores
  localparam int DEF_MAX_KEYS = 256;
  localparam int DEF_MAX_DIMS = 3;

  // field and datapath widths
  localparam int TW          = 16;  // q2.14 time or value
  localparam int DIFF_W      = 17;  // difference of two q2.14 words
  localparam int PROD_W      = 34;  // product of two differences
  localparam int NUM_W       = 34;  // rounded dividend 2|p| + |d|
  localparam int DEN2_W      = 18;  // doubled divisor 2|d|
  localparam int REM_W       = 19;  // divider remainder
  localparam int DIV_CNT_W   = 6;   // divider step counter
  localparam int SUM_W       = 36;  // value plus quotient before clamping
  localparam int DIM_COUNT_W = 2;
  localparam int KEY_COUNT_W = 9;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIM_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COUNT = 2'd1;
  localparam logic [DIM_COUNT_W-1:0] DIM_COUNT_RESET = 2'd1;

  // item kinds and slot codes
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam logic [1:0] SLOT_TIME = 2'd0;

  // key read address selection
  localparam logic [1:0] RD_FIRST = 2'd0;  // key 1
  localparam logic [1:0] RD_NEXT  = 2'd1;  // scan pointer plus one
  localparam logic [1:0] RD_PREV  = 2'd2;  // segment start key
  localparam logic [1:0] RD_CUR   = 2'd3;  // segment end key

  // saturation limits
  localparam logic signed [TW-1:0] Q_MAX = 16'sh7fff;
  localparam logic signed [TW-1:0] Q_MIN = 16'sh8000;

  // input item
  typedef struct packed {
    logic                 kind;
    logic [7:0]           key_index;
    logic [1:0]           slot;
    logic signed [TW-1:0] write_value;
    logic signed [TW-1:0] sample_time;
    logic [1:0]           dimension;
  } item_t;

  // result item
  typedef struct packed {
    logic signed [TW-1:0] sampled_value;
    logic                 status;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic       write;
    logic       load_sample;
    logic       scan_init;
    logic       scan_step;
    logic [1:0] rd_sel;
    logic       cap_prev;
    logic       cap_next;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       res_err;
    logic       res_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic reject;
    logic scan_more;
    logic den_zero;
    logic div_last;
  } sts_t;

endpackage

>>> hdl/kcs_ram.sv
// generic single write port ram with registered read
module kcs_ram
  import kcs_pkg::*;
#(
  parameter int WIDTH = TW,
  parameter int DEPTH = DEF_MAX_KEYS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/kcs_datapath.sv
// key stores, segment scan pointer, multiplier, divider and result register
module kcs_datapath
  import kcs_pkg::*;
#(
  parameter int MAX_KEYS = DEF_MAX_KEYS,
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  item_t                  item,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output result_t                result
);

  localparam int KW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int VD  = MAX_KEYS * MAX_DIMS;
  localparam int VAW = $clog2(VD);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(Q_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(Q_MIN);

  logic [DIM_COUNT_W-1:0]   dim_count;
  logic [KEY_COUNT_W-1:0]   key_count;
  logic [CW-1:0]            cnt_eff;
  logic                     too_few;
  logic                     bad_dim;
  logic                     key_ok;
  logic                     we_t;
  logic                     we_v;
  logic [VAW-1:0]           wv_addr;
  logic [KW-1:0]            rd_key;
  logic [VAW-1:0]           rv_addr;
  logic [TW-1:0]            t_rd;
  logic [TW-1:0]            v_rd;
  logic signed [TW-1:0]     t_reg;
  logic [1:0]               dim_reg;
  logic [CW-1:0]            nk;
  logic signed [TW-1:0]     pt;
  logic signed [TW-1:0]     pv;
  logic signed [TW-1:0]     nt;
  logic signed [TW-1:0]     nv;
  logic signed [DIFF_W-1:0] dv;
  logic signed [DIFF_W-1:0] dt;
  logic signed [DIFF_W-1:0] dn;
  logic signed [PROD_W-1:0] prod;
  logic signed [DIFF_W-1:0] den;
  logic [PROD_W-1:0]        abs_prod;
  logic [DIFF_W-1:0]        abs_den;
  logic                     neg;
  logic [DEN2_W-1:0]        dden;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         rem_sh;
  logic                     rem_ge;
  logic [NUM_W-1:0]         quo;
  logic [DIV_CNT_W-1:0]     dcnt;
  logic signed [SUM_W-1:0]  pv_ext;
  logic signed [SUM_W-1:0]  q_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [TW-1:0]     sat_val;
  result_t                  res_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= DIM_COUNT_RESET;
      key_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIM_COUNT: dim_count <= cfg_data[DIM_COUNT_W-1:0];
        CFG_KEY_COUNT: key_count <= cfg_data[KEY_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // key count limited to the store, rejection checks
  always_comb begin
    if (int'(key_count) > MAX_KEYS) begin
      cnt_eff = CW'(MAX_KEYS);
    end else begin
      cnt_eff = CW'(key_count);
    end
  end
  assign too_few    = cnt_eff < CW'(2);
  assign bad_dim    = (item.dimension >= dim_count) || (int'(item.dimension) >= MAX_DIMS);
  assign sts.reject = too_few || bad_dim;

  // key writes, out of range slots and keys dropped
  assign key_ok  = int'(item.key_index) < MAX_KEYS;
  assign we_t    = cmd.write && key_ok && (item.slot == SLOT_TIME);
  assign we_v    = cmd.write && key_ok && (item.slot != SLOT_TIME)
                   && (int'(item.slot) <= MAX_DIMS);
  assign wv_addr = VAW'(item.key_index) * VAW'(MAX_DIMS) + VAW'(item.slot - 2'd1);

  // read address of the key in use
  always_comb begin
    case (cmd.rd_sel)
      RD_FIRST: rd_key = KW'(1);
      RD_NEXT:  rd_key = KW'(nk + CW'(1));
      RD_PREV:  rd_key = KW'(nk - CW'(1));
      default:  rd_key = KW'(nk);
    endcase
  end
  assign rv_addr = VAW'(rd_key) * VAW'(MAX_DIMS) + VAW'(dim_reg);

  kcs_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_KEYS)
  ) u_time_ram (
    .clk     (clk),
    .wr_en   (we_t),
    .wr_addr (KW'(item.key_index)),
    .wr_data (item.write_value),
    .rd_addr (rd_key),
    .rd_data (t_rd)
  );

  kcs_ram #(
    .WIDTH (TW),
    .DEPTH (VD)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (we_v),
    .wr_addr (wv_addr),
    .wr_data (item.write_value),
    .rd_addr (rv_addr),
    .rd_data (v_rd)
  );

  // scan goes on while the current end key is not the last and lies before the sample time
  assign sts.scan_more = ((nk + CW'(1)) < cnt_eff) && ($signed(t_rd) < t_reg);

  // segment differences
  assign dv = $signed({nv[TW-1], nv}) - $signed({pv[TW-1], pv});
  assign dt = $signed({t_reg[TW-1], t_reg}) - $signed({pt[TW-1], pt});
  assign dn = $signed({nt[TW-1], nt}) - $signed({pt[TW-1], pt});
  assign sts.den_zero = (nt == pt);

  // magnitudes for the divider
  assign abs_prod = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign abs_den  = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

  // restoring divider step
  assign rem_sh       = {rem[REM_W-2:0], quo[NUM_W-1]};
  assign rem_ge       = rem_sh >= REM_W'(dden);
  assign sts.div_last = dcnt == DIV_CNT_W'(NUM_W - 1);

  // sample, scan, segment and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      t_reg   <= item.sample_time;
      dim_reg <= item.dimension;
    end
    if (cmd.scan_init) begin
      nk <= CW'(1);
    end else if (cmd.scan_step) begin
      nk <= nk + CW'(1);
    end
    if (cmd.cap_prev) begin
      pt <= $signed(t_rd);
      pv <= $signed(v_rd);
    end
    if (cmd.cap_next) begin
      nt <= $signed(t_rd);
      nv <= $signed(v_rd);
    end
    if (cmd.mul) begin
      prod <= dv * dt;
      den  <= dn;
    end
    // rounded quotient is floor((2|p| + |d|) / 2|d|)
    if (cmd.div_init) begin
      neg  <= prod[PROD_W-1] ^ den[DIFF_W-1];
      quo  <= {abs_prod[PROD_W-2:0], 1'b0} + NUM_W'(abs_den);
      dden <= {abs_den, 1'b0};
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? (rem_sh - REM_W'(dden)) : rem_sh;
      quo  <= {quo[NUM_W-2:0], rem_ge};
      dcnt <= dcnt + DIV_CNT_W'(1);
    end
  end

  // start value plus signed quotient, clamped to 16 bits
  assign pv_ext = SUM_W'(pv);
  assign q_ext  = $signed(SUM_W'(quo));
  assign sum    = neg ? (pv_ext - q_ext) : (pv_ext + q_ext);
  always_comb begin
    if (sum > SAT_HI) begin
      sat_val = Q_MAX;
    end else if (sum < SAT_LO) begin
      sat_val = Q_MIN;
    end else begin
      sat_val = TW'(sum);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_err) begin
      res_q.sampled_value <= '0;
      res_q.status        <= 1'b1;
    end else if (cmd.res_load) begin
      res_q.sampled_value <= sts.den_zero ? pv : sat_val;
      res_q.status        <= 1'b0;
    end
  end
  assign result = res_q;

endmodule

>>> hdl/kcs_ctrl.sv
// sequencer for key writes, segment scan, fetch, multiply and divide
module kcs_ctrl
  import kcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  input  logic item_kind,
  output logic item_ready,
  output logic result_valid,
  input  logic result_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_REJECT  = 4'd1;
  localparam logic [3:0] S_SCAN0   = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_FETCH_P = 4'd4;
  localparam logic [3:0] S_FETCH_N = 4'd5;
  localparam logic [3:0] S_CAP_N   = 4'd6;
  localparam logic [3:0] S_MUL     = 4'd7;
  localparam logic [3:0] S_PREP    = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_FINISH  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;
  logic       result_valid_next;

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item_kind == KIND_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load_sample = 1'b1;
            state_next      = sts.reject ? S_REJECT : S_SCAN0;
          end
        end
      end
      S_REJECT: begin
        if (out_free) begin
          cmd.res_err = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCAN0: begin
        cmd.rd_sel    = RD_FIRST;
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_sel = RD_NEXT;
        if (sts.scan_more) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_next = S_FETCH_P;
        end
      end
      S_FETCH_P: begin
        cmd.rd_sel = RD_PREV;
        state_next = S_FETCH_N;
      end
      S_FETCH_N: begin
        cmd.rd_sel   = RD_CUR;
        cmd.cap_prev = 1'b1;
        state_next   = S_CAP_N;
      end
      S_CAP_N: begin
        cmd.cap_next = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sts.den_zero ? S_FINISH : S_PREP;
      end
      S_PREP: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    result_valid_next = result_valid;
    if (cmd.res_err || cmd.res_load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

>>> hdl/keyframe_curve_sampler_unit.sv
// top level of the piecewise-linear keyframe curve sampler
//
// Items enter on item_valid/item_ready. A write item (kind 0) stores one key
// time or one dimension value and gives no result. A sample item (kind 1)
// gives one item on result_valid/result_ready.
// Configuration registers (dimension count, key count) are written on
// cfg_valid/cfg_ready, which is always ready; write them only while idle.
// A sample scans the key-time memory one key per cycle from key 1, reads the
// two end keys of the segment, multiplies once and runs a bit-serial divider
// of 34 steps; an equal-time segment skips the divider, and a rejected sample
// (too few keys or bad dimension) skips the scan. The next item is taken in
// the cycle after the result is loaded, so a new sample is not taken until
// the last one is through, while write items are taken every cycle.
// The result sits in an output register: the next item is taken while it
// waits, but a finished sample holds until the receiver has taken the last.
// Reset clears the registers to one dimension and no keys; the key memories
// are not cleared and must be written before they are sampled.
module keyframe_curve_sampler_unit
  import kcs_pkg::*;
#(
  parameter int MAX_KEYS = DEF_MAX_KEYS,
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  kcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_kind    (item.kind),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // stores and arithmetic
  kcs_datapath #(
    .MAX_KEYS (MAX_KEYS),
    .MAX_DIMS (MAX_DIMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

>>> tb/tb_keyframe_curve_sampler_unit.sv
`timescale 1ns / 100ps
// testbench for the keyframe curve sampler: directed and random items checked against a predictor
module tb_keyframe_curve_sampler_unit;
  import kcs_pkg::*;

  localparam int NKEYS = DEF_MAX_KEYS;
  localparam int NDIMS = DEF_MAX_DIMS;

  // register indexes that map to nothing
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int TARGET_ITEMS  = 1800;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 64;
  localparam int MAX_REPORTS   = 10;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_ready;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  // local copy of the curve and the registers
  logic signed [TW-1:0]   curve_times [NKEYS];
  logic signed [TW-1:0]   curve_values [NKEYS][NDIMS];
  bit                     time_set [NKEYS];
  bit                     value_set [NKEYS][NDIMS];
  logic [DIM_COUNT_W-1:0] dims_reg;
  logic [KEY_COUNT_W-1:0] keys_reg;

  result_t expected_samples [$];

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  writes_sent  = 0;
  int  samples_sent = 0;
  int  rejects_sent = 0;
  int  cfg_writes   = 0;
  int  stall_left   = 0;
  bit  quiet        = 1'b0;  // no idling on either side

  keyframe_curve_sampler_unit uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // clock
  always #2 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("run limit reached with %0d samples outstanding", expected_samples.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int active_dims();
    return (dims_reg > NDIMS) ? NDIMS : int'(dims_reg);
  endfunction

  function automatic int active_keys();
    return (keys_reg > NKEYS) ? NKEYS : int'(keys_reg);
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint an, ad, q;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q  = (2 * an + ad) / (2 * ad);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic result_t sample_curve(logic signed [TW-1:0] t, logic [1:0] dim);
    result_t r;
    int      seg_end, count;
    longint  pt, nt, pv, nv, tl, acc;
    r     = '0;
    count = active_keys();
    // too few keys or dimension out of range
    if (count < 2 || int'(dim) >= active_dims()) begin
      r.status = 1'b1;
      return r;
    end
    // forward scan for the segment end key
    seg_end = 1;
    while (seg_end + 1 < count && curve_times[seg_end] < t) seg_end++;
    pt  = curve_times[seg_end-1];
    nt  = curve_times[seg_end];
    pv  = curve_values[seg_end-1][dim];
    nv  = curve_values[seg_end][dim];
    tl  = t;
    // equal segment times keep the earlier value
    acc = pv;
    if (nt != pt) acc = pv + round_div((nv - pv) * (tl - pt), nt - pt);
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    r.sampled_value = acc[TW-1:0];
    r.status        = 1'b0;
    return r;
  endfunction

  function automatic void store_word(item_t it);
    if (it.slot == SLOT_TIME) begin
      curve_times[it.key_index] = it.write_value;
      time_set[it.key_index]    = 1'b1;
    end else if (int'(it.slot) - 1 < NDIMS) begin
      curve_values[it.key_index][int'(it.slot) - 1] = it.write_value;
      value_set[it.key_index][int'(it.slot) - 1]    = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // present one item, predict it, hold until accepted
  task automatic send_item(item_t it);
    result_t want;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    if (it.kind == KIND_SAMPLE) begin
      want = sample_curve(it.sample_time, it.dimension);
      expected_samples.push_back(want);
      samples_sent++;
      if (want.status) rejects_sent++;
    end else begin
      store_word(it);
      writes_sent++;
    end
    items_sent++;
    do @(posedge clk); while (!item_ready);
  endtask

  // drop valid and let every sample come out
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DIM_COUNT) dims_reg = data[DIM_COUNT_W-1:0];
    else if (idx == CFG_KEY_COUNT) keys_reg = data[KEY_COUNT_W-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_word(int key, int slot_sel, logic signed [TW-1:0] val);
    item_t it;
    it.kind        = KIND_WRITE;
    it.key_index   = 8'(key);
    it.slot        = 2'(slot_sel);
    it.write_value = val;
    it.sample_time = 16'($urandom);
    it.dimension   = 2'($urandom);
    send_item(it);
  endtask

  // write any key word that the coming sample could read but was never stored
  task automatic fill_unwritten(int n, logic [1:0] dim);
    int k;
    for (k = 0; k < n; k++) begin
      if (!time_set[k]) write_word(k, SLOT_TIME, 16'($urandom));
      if (!value_set[k][dim]) write_word(k, int'(dim) + 1, 16'($urandom));
    end
  endtask

  task automatic sample_at(logic signed [TW-1:0] t, logic [1:0] dim);
    item_t it;
    if (active_keys() >= 2 && int'(dim) < active_dims()) fill_unwritten(active_keys(), dim);
    it.kind        = KIND_SAMPLE;
    it.key_index   = 8'($urandom);
    it.slot        = 2'($urandom);
    it.write_value = 16'($urandom);
    it.sample_time = t;
    it.dimension   = dim;
    send_item(it);
  endtask

  // ---------------------------------------------------------------- checking

  // receiver stalls in bursts
  always @(negedge clk) begin
    logic ready_next;
    ready_next = 1'b1;
    if (!quiet) begin
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        ready_next = 1'b0;
      end
    end
    result_ready <= ready_next;
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result item: value %0d status %0b",
                   result.sampled_value, result.status);
      end else begin
        want = expected_samples.pop_front();
        if (result.sampled_value !== want.sampled_value || result.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected value %0d status %0b, got value %0d status %0b",
                     want.sampled_value, want.status, result.sampled_value, result.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // registers straight after reset: no keys, so every sample is rejected
  task automatic test_reset_defaults();
    sample_at(16'sh8000, 2'd0);
    sample_at(16'sh7fff, 2'd3);
  endtask

  // extreme times and values, equal and falling segment times, rounding ties
  task automatic test_curve_extremes();
    write_reg(CFG_DIM_COUNT, 9'd3);
    write_reg(CFG_KEY_COUNT, 9'd3);
    write_word(0, SLOT_TIME, 16'sd0);
    write_word(1, SLOT_TIME, 16'sd0);
    write_word(2, SLOT_TIME, -16'sd16384);
    write_word(0, 1, 16'sh8000);
    write_word(1, 1, 16'sh7fff);
    write_word(2, 1, 16'sd100);
    write_word(0, 2, 16'sh7fff);
    write_word(1, 2, 16'sh8000);
    write_word(2, 2, 16'sd0);
    sample_at(16'sh8000, 2'd0);
    sample_at(16'sh7fff, 2'd0);
    sample_at(16'sh7fff, 2'd1);
    sample_at(-16'sd16384, 2'd0);
    sample_at(16'sd0, 2'd2);
    sample_at(16'sd0, 2'd3);
    // half-way points on a two-step segment
    write_word(2, SLOT_TIME, 16'sd2);
    write_word(1, 1, 16'sd0);
    write_word(2, 1, 16'sd1);
    sample_at(16'sd1, 2'd0);
    write_word(2, 1, -16'sd1);
    sample_at(16'sd1, 2'd0);
  endtask

  // spare indexes, zero dimensions, too few keys
  task automatic test_register_map();
    write_reg(CFG_SPARE_LO, 9'h1ff);
    write_reg(CFG_SPARE_HI, 9'h000);
    sample_at(16'sd1, 2'd0);
    write_reg(CFG_DIM_COUNT, 9'h1fc);
    sample_at(16'sd1, 2'd0);
    write_reg(CFG_DIM_COUNT, 9'd3);
    write_reg(CFG_KEY_COUNT, 9'd1);
    sample_at(16'sd1, 2'd0);
    write_reg(CFG_KEY_COUNT, 9'd0);
    sample_at(16'sd1, 2'd1);
    write_reg(CFG_KEY_COUNT, 9'd2);
    sample_at(16'sh7fff, 2'd2);
  endtask

  // load a curve of n keys in one of several shapes
  task automatic build_curve(int n, int style, int value_dims);
    int                   k, d, tcur, step_max;
    logic signed [TW-1:0] tv;
    if (n == 0) return;
    step_max = (style == 1) ? 4 : 65535 / n;
    if (style == 1) tcur = int'($urandom_range(0, 65535)) - 32768;
    else tcur = -32768 + int'($urandom_range(0, step_max));
    for (k = 0; k < n; k++) begin
      // style 2 gives unordered times, style 3 repeats some of them
      if (style == 2) begin
        tv = 16'($urandom);
      end else begin
        if (tcur > 32767) tcur = 32767;
        tv = 16'(tcur);
        if (style == 3 && $urandom_range(0, 2) == 0) tcur = tcur;
        else tcur = tcur + int'($urandom_range(1, step_max));
      end
      write_word(k, SLOT_TIME, tv);
      for (d = 0; d < value_dims; d++) begin
        if (style == 1) write_word(k, d + 1, 16'(int'($urandom_range(0, 16)) - 8));
        else write_word(k, d + 1, 16'($urandom));
      end
    end
  endtask

  task automatic random_item(int n);
    int                   r, m, k, top_dim;
    logic signed [TW-1:0] t;
    logic [1:0]           dim;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      // stray or curve-changing key writes
      if (n > 0 && r < 10) k = $urandom_range(0, n - 1);
      else k = $urandom_range(0, NKEYS - 1);
      write_word(k, $urandom_range(0, 3), 16'($urandom));
    end else begin
      top_dim = (active_dims() > 0) ? active_dims() - 1 : 0;
      if (r < 90) dim = 2'($urandom_range(0, top_dim));
      else dim = 2'($urandom_range(0, 3));
      m = $urandom_range(0, 9);
      t = 16'($urandom);
      if (m == 4) t = 16'sh8000;
      else if (m == 5) t = 16'sh7fff;
      else if (m >= 6 && n > 0) begin
        // on or next to a key time
        k = $urandom_range(0, n - 1);
        if (time_set[k]) begin
          if (m == 9) t = curve_times[k];
          else t = curve_times[k] + 16'(int'($urandom_range(0, 6)) - 3);
        end
      end
      sample_at(t, dim);
    end
  endtask

  // phases of random register settings and curves, idling off near the end
  task automatic test_random_curves();
    int                   phase, n, r, dims, style, value_dims, j;
    logic [KEY_COUNT_W-1:0] n_reg;
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      quiet = (items_sent > TARGET_ITEMS * 85 / 100);
      r = $urandom_range(0, 19);
      if (phase == 2) n_reg = 9'h1ff;
      else if (phase == 6) n_reg = 9'd256;
      else if (r == 0) n_reg = 9'($urandom_range(0, 1));
      else if (r == 1) n_reg = 9'($urandom_range(13, 48));
      else n_reg = 9'($urandom_range(2, 12));
      dims = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      write_reg(CFG_DIM_COUNT, {7'($urandom), 2'(dims)});
      write_reg(CFG_KEY_COUNT, n_reg);
      n = active_keys();
      style = (n > 48) ? 0 : $urandom_range(0, 3);
      value_dims = (n > 48) ? 1 : active_dims();
      build_curve(n, style, value_dims);
      for (j = 0; j < 30; j++) random_item(n);
      phase++;
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    dims_reg = DIM_COUNT_RESET;
    keys_reg = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_curve_extremes();
    test_register_map();
    test_random_curves();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d key writes, %0d samples of which %0d rejected",
             items_sent, writes_sent, samples_sent, rejects_sent);
    $display("%0d register writes, %0d mismatches", cfg_writes, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
